@@ hw/rtl/mcpg_pkg.sv @@
// mcpg_pkg: shared types, codes and constants of the midi clock pulse generator
// used by mcpg_div, mcpg_ctrl and midi_clock_pulse_generator_top
package mcpg_pkg;

	// tick width and derived widths
	localparam int TICK_W = 32;
	localparam int LAST_W = TICK_W + 1;
	localparam int DSR_W = 22;
	localparam int STEP_W = $clog2(TICK_W);

	// field widths
	localparam int ACT_W = 3;
	localparam int KIND_W = 3;
	localparam int BEAT_W = 32;
	localparam int COUNT_W = 16;
	localparam int PPQ_W = 15;
	localparam int MODE_W = 2;
	localparam int SPW_W = 9;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 15;

	// ppqn/24 = (ppqn/8)/3, the /3 as multiply by 2731 and shift by 13
	localparam int X8_W = PPQ_W - 3;
	localparam int RECIP_W = 24;
	localparam int RECIP_SHIFT = 13;
	localparam logic [RECIP_W-1:0] RECIP3 = RECIP_W'(2731);
	localparam int CT_W = 11;
	localparam int PP16_W = PPQ_W - 2;

	// config register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PPQN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SPW = 2'd2;

	// config reset values
	localparam logic [PPQ_W-1:0] PPQN_RESET = 15'd192;
	localparam logic [MODE_W-1:0] MODE_RESET = 2'd0;
	localparam logic [SPW_W-1:0] SPW_RESET = 9'd64;

	// clock modes
	localparam logic [MODE_W-1:0] MODE_OFF = 2'd0;
	localparam logic [MODE_W-1:0] MODE_POSITION = 2'd1;
	localparam logic [MODE_W-1:0] MODE_MODULO = 2'd2;
	localparam logic [MODE_W-1:0] MODE_DISABLED = 2'd3;

	// action codes
	localparam logic [ACT_W-1:0] ACT_INIT = 3'd0;
	localparam logic [ACT_W-1:0] ACT_CONTINUE = 3'd1;
	localparam logic [ACT_W-1:0] ACT_START = 3'd2;
	localparam logic [ACT_W-1:0] ACT_STOP = 3'd3;
	localparam logic [ACT_W-1:0] ACT_CLOCK = 3'd4;

	// event kinds
	localparam logic [KIND_W-1:0] EV_NONE = 3'd0;
	localparam logic [KIND_W-1:0] EV_START = 3'd1;
	localparam logic [KIND_W-1:0] EV_CONTINUE = 3'd2;
	localparam logic [KIND_W-1:0] EV_STOP = 3'd3;
	localparam logic [KIND_W-1:0] EV_CLOCK = 3'd4;

	typedef struct packed {
		logic [ACT_W-1:0] action;
		logic [TICK_W-1:0] tick;
	} item_t;

	typedef struct packed {
		logic [KIND_W-1:0] event_kind;
		logic [BEAT_W-1:0] beat_position;
		logic [COUNT_W-1:0] pulse_count;
	} result_t;

	typedef struct packed {
		logic [PPQ_W-1:0] pulses_per_quarter;
		logic [MODE_W-1:0] clock_mode;
		logic [SPW_W-1:0] sixteenths_per_wrap;
	} cfg_t;

	typedef struct packed {
		logic start;
		logic [TICK_W-1:0] dividend;
		logic [DSR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic [TICK_W-1:0] quotient;
		logic [DSR_W-1:0] remainder;
	} div_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_A_GO,
		ST_DIV_A,
		ST_DIV_B_GO,
		ST_DIV_B,
		ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_CONT,
		OP_INIT_START,
		OP_START,
		OP_STOP,
		OP_CLOCK,
		OP_CLOCK_ZERO
	} op_t;

endpackage

@@ hw/rtl/mcpg_div.sv @@
// mcpg_div: shared radix-2 restoring divider, one quotient bit per cycle
// depends on mcpg_pkg
module mcpg_div (
	input  logic                clk,
	input  logic                arst_n,
	input  mcpg_pkg::div_req_t  req,
	output mcpg_pkg::div_rsp_t  rsp
);

	logic                                busy_q;
	logic                                done_q;
	logic [mcpg_pkg::STEP_W-1:0]         step_q;
	logic [mcpg_pkg::TICK_W-1:0]         dvd_q;
	logic [mcpg_pkg::DSR_W-1:0]          dsr_q;
	logic [mcpg_pkg::DSR_W-1:0]          rem_q;
	logic [mcpg_pkg::DSR_W:0]            trial;
	logic                                qbit;
	logic [mcpg_pkg::DSR_W-1:0]          rem_next;

	always_comb begin
		trial = {rem_q, dvd_q[mcpg_pkg::TICK_W-1]};
		qbit = trial >= {1'b0, dsr_q};
		if (qbit) begin
			rem_next = mcpg_pkg::DSR_W'(trial - {1'b0, dsr_q});
		end else begin
			rem_next = trial[mcpg_pkg::DSR_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == mcpg_pkg::STEP_W'(mcpg_pkg::TICK_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient bits shift into the dividend register
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[mcpg_pkg::TICK_W-2:0], qbit};
			rem_q <= rem_next;
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quotient = dvd_q;
	assign rsp.remainder = rem_q;

`ifndef SYNTH
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("divider started while busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("divider done while still stepping");
`endif

endmodule

@@ hw/rtl/mcpg_ctrl.sv @@
// mcpg_ctrl: sequencer, last clocked tick and result register
// depends on mcpg_pkg; drives the shared divider mcpg_div
module mcpg_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  mcpg_pkg::cfg_t      cfg,
	input  logic                item_valid,
	output logic                item_stall,
	input  mcpg_pkg::item_t     item,
	output logic                result_valid,
	input  logic                result_stall,
	output mcpg_pkg::result_t   result,
	output mcpg_pkg::div_req_t  div_req,
	input  mcpg_pkg::div_rsp_t  div_rsp
);

	mcpg_pkg::state_t                    state_q;
	mcpg_pkg::state_t                    state_d;
	mcpg_pkg::op_t                       op_q;
	mcpg_pkg::op_t                       op_d;
	logic [mcpg_pkg::TICK_W-1:0]         tick_q;
	logic [mcpg_pkg::LAST_W-1:0]         last_q;
	logic [mcpg_pkg::TICK_W-1:0]         qa_q;
	logic [mcpg_pkg::DSR_W-1:0]          ra_q;
	logic [mcpg_pkg::DSR_W-1:0]          dsr_a_q;
	logic                                result_valid_q;
	mcpg_pkg::result_t                   result_q;

	logic                                clk_on;
	logic                                accept;
	logic                                write_res;
	logic [mcpg_pkg::PP16_W-1:0]         pp16;
	logic [mcpg_pkg::RECIP_W-1:0]        ct_prod;
	logic [mcpg_pkg::CT_W-1:0]           ct;
	logic [mcpg_pkg::SPW_W-1:0]          spw;
	logic [mcpg_pkg::DSR_W-1:0]          span;
	logic [mcpg_pkg::TICK_W-1:0]         base;
	logic [mcpg_pkg::LAST_W-1:0]         sum;
	logic [mcpg_pkg::LAST_W-1:0]         align_last;
	logic [mcpg_pkg::LAST_W-1:0]         count_raw;
	logic [mcpg_pkg::COUNT_W-1:0]        count;
	mcpg_pkg::result_t                   res_d;
	logic [mcpg_pkg::LAST_W-1:0]         last_d;

	// divisors, a zero divisor acts as one
	always_comb begin
		pp16 = cfg.pulses_per_quarter[mcpg_pkg::PPQ_W-1:2];
		if (pp16 == '0) begin
			pp16 = mcpg_pkg::PP16_W'(1);
		end
		ct_prod = mcpg_pkg::RECIP_W'(cfg.pulses_per_quarter[mcpg_pkg::PPQ_W-1:3])
			* mcpg_pkg::RECIP3;
		ct = ct_prod[mcpg_pkg::RECIP_SHIFT +: mcpg_pkg::CT_W];
		if (ct == '0) begin
			ct = mcpg_pkg::CT_W'(1);
		end
		spw = cfg.sixteenths_per_wrap;
		if (spw == '0) begin
			spw = mcpg_pkg::SPW_W'(1);
		end
		span = mcpg_pkg::DSR_W'(pp16) * mcpg_pkg::DSR_W'(spw);
	end

	assign clk_on = (cfg.clock_mode == mcpg_pkg::MODE_POSITION)
		|| (cfg.clock_mode == mcpg_pkg::MODE_MODULO);
	assign accept = item_valid && (state_q == mcpg_pkg::ST_IDLE);
	assign write_res = (state_q == mcpg_pkg::ST_DONE) && (!result_valid_q || !result_stall);

	// next state, op decode and divider requests
	always_comb begin
		state_d = state_q;
		op_d = op_q;
		div_req.start = 1'b0;
		div_req.dividend = tick_q;
		div_req.divisor = mcpg_pkg::DSR_W'(ct);
		case (state_q)
			mcpg_pkg::ST_IDLE: begin
				case (item.action)
					mcpg_pkg::ACT_INIT: begin
						if (cfg.clock_mode == mcpg_pkg::MODE_POSITION && item.tick != '0) begin
							op_d = mcpg_pkg::OP_CONT;
						end else if (cfg.clock_mode == mcpg_pkg::MODE_MODULO
							|| item.tick == '0) begin
							op_d = mcpg_pkg::OP_INIT_START;
						end else begin
							op_d = mcpg_pkg::OP_NONE;
						end
					end
					mcpg_pkg::ACT_CONTINUE: op_d = mcpg_pkg::OP_CONT;
					mcpg_pkg::ACT_START: op_d = mcpg_pkg::OP_START;
					mcpg_pkg::ACT_STOP: op_d = mcpg_pkg::OP_STOP;
					mcpg_pkg::ACT_CLOCK: begin
						if (!clk_on) begin
							op_d = mcpg_pkg::OP_NONE;
						end else if ($signed(last_q) < $signed({1'b0, item.tick})) begin
							op_d = mcpg_pkg::OP_CLOCK;
						end else begin
							op_d = mcpg_pkg::OP_CLOCK_ZERO;
						end
					end
					default: op_d = mcpg_pkg::OP_NONE;
				endcase
				if (!item_valid) begin
					op_d = op_q;
				end else if (op_d == mcpg_pkg::OP_CONT || op_d == mcpg_pkg::OP_INIT_START
					|| op_d == mcpg_pkg::OP_CLOCK) begin
					state_d = mcpg_pkg::ST_DIV_A_GO;
				end else begin
					state_d = mcpg_pkg::ST_DONE;
				end
			end
			mcpg_pkg::ST_DIV_A_GO: begin
				div_req.start = 1'b1;
				case (op_q)
					mcpg_pkg::OP_CONT: div_req.divisor = mcpg_pkg::DSR_W'(pp16);
					mcpg_pkg::OP_INIT_START: div_req.divisor = span;
					default: div_req.divisor = mcpg_pkg::DSR_W'(ct);
				endcase
				state_d = mcpg_pkg::ST_DIV_A;
			end
			mcpg_pkg::ST_DIV_A: begin
				if (div_rsp.done) begin
					if (op_q == mcpg_pkg::OP_CLOCK) begin
						state_d = mcpg_pkg::ST_DIV_B_GO;
					end else begin
						state_d = mcpg_pkg::ST_DONE;
					end
				end
			end
			mcpg_pkg::ST_DIV_B_GO: begin
				div_req.start = 1'b1;
				div_req.dividend = last_q[mcpg_pkg::TICK_W-1:0];
				state_d = mcpg_pkg::ST_DIV_B;
			end
			mcpg_pkg::ST_DIV_B: begin
				if (div_rsp.done) begin
					state_d = mcpg_pkg::ST_DONE;
				end
			end
			mcpg_pkg::ST_DONE: begin
				if (write_res) begin
					state_d = mcpg_pkg::ST_IDLE;
				end
			end
			default: state_d = mcpg_pkg::ST_IDLE;
		endcase
	end

	// alignment: round up to the first divisor (sixteenth or span), minus one, saturating at the top tick
	always_comb begin
		base = tick_q - mcpg_pkg::TICK_W'(ra_q);
		sum = {1'b0, base} + mcpg_pkg::LAST_W'(dsr_a_q);
		if (ra_q == '0) begin
			align_last = {1'b0, tick_q} - mcpg_pkg::LAST_W'(1);
		end else if (sum[mcpg_pkg::TICK_W]) begin
			align_last = {1'b0, {mcpg_pkg::TICK_W{1'b1}}};
		end else begin
			align_last = sum - mcpg_pkg::LAST_W'(1);
		end
	end

	// pulse count: floor(tick/ct) minus floor(last/ct), or plus one from -1
	always_comb begin
		if (&last_q) begin
			count_raw = {1'b0, qa_q} + mcpg_pkg::LAST_W'(1);
		end else begin
			count_raw = {1'b0, qa_q} - {1'b0, div_rsp.quotient};
		end
		if (count_raw > mcpg_pkg::LAST_W'({mcpg_pkg::COUNT_W{1'b1}})) begin
			count = '1;
		end else begin
			count = count_raw[mcpg_pkg::COUNT_W-1:0];
		end
	end

	// result and new last tick per op
	always_comb begin
		res_d.event_kind = mcpg_pkg::EV_NONE;
		res_d.beat_position = '0;
		res_d.pulse_count = '0;
		last_d = last_q;
		case (op_q)
			mcpg_pkg::OP_CONT: begin
				last_d = align_last;
				if (clk_on) begin
					res_d.event_kind = mcpg_pkg::EV_CONTINUE;
					res_d.beat_position = mcpg_pkg::BEAT_W'(qa_q);
				end
			end
			mcpg_pkg::OP_INIT_START: begin
				last_d = align_last;
				if (clk_on) begin
					res_d.event_kind = mcpg_pkg::EV_START;
				end
			end
			mcpg_pkg::OP_START: begin
				last_d = '1;
				if (clk_on) begin
					res_d.event_kind = mcpg_pkg::EV_START;
				end
			end
			mcpg_pkg::OP_STOP: begin
				last_d = '1;
				if (cfg.clock_mode != mcpg_pkg::MODE_OFF) begin
					res_d.event_kind = mcpg_pkg::EV_STOP;
				end
			end
			mcpg_pkg::OP_CLOCK: begin
				last_d = {1'b0, tick_q};
				res_d.event_kind = mcpg_pkg::EV_CLOCK;
				res_d.pulse_count = count;
			end
			mcpg_pkg::OP_CLOCK_ZERO: res_d.event_kind = mcpg_pkg::EV_CLOCK;
			default: res_d.event_kind = mcpg_pkg::EV_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mcpg_pkg::ST_IDLE;
			op_q <= mcpg_pkg::OP_NONE;
			last_q <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			op_q <= op_d;
			if (write_res) begin
				last_q <= last_d;
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tick_q <= item.tick;
		end
		if (state_q == mcpg_pkg::ST_DIV_A_GO) begin
			dsr_a_q <= div_req.divisor;
		end
		if (state_q == mcpg_pkg::ST_DIV_A && div_rsp.done) begin
			qa_q <= div_rsp.quotient;
			ra_q <= div_rsp.remainder;
		end
		if (write_res) begin
			result_q <= res_d;
		end
	end

	assign item_stall = state_q != mcpg_pkg::ST_IDLE;
	assign result_valid = result_valid_q;
	assign result = result_q;

`ifndef SYNTH
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == mcpg_pkg::ST_DIV_A || state_q == mcpg_pkg::ST_DIV_B))
		else $error("divider result outside a wait state");
	a_last_range: assert property (@(posedge clk) disable iff (!arst_n)
		!last_q[mcpg_pkg::TICK_W] || (&last_q))
		else $error("last clocked tick below -1");
	a_leave_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != mcpg_pkg::ST_IDLE))
		else $error("accepted transaction did not leave idle");
`endif

endmodule

@@ hw/rtl/midi_clock_pulse_generator_top.sv @@
// midi_clock_pulse_generator_top: config registers, sequencer and shared divider
// depends on mcpg_pkg, mcpg_div and mcpg_ctrl
//
// turns sequencer transport and clock transactions into midi clock events
// item channel: item_valid/item_stall with payload item (action, tick)
// result channel: result_valid/result_stall with payload result
//   (event_kind, beat_position, pulse_count); exactly one result per item
// config: cfg_write with cfg_index/cfg_data, one register per write,
//   writes only while the block is idle (a rule for the user, not enforced), unknown indexes are ignored
// one item at a time: item_stall is high from acceptance until the result
//   is loaded into the output register
// start, stop, init without alignment and clock with no progress go from
//   idle straight to the final state, without a division
// continue and init with alignment need one division
// clock with progress needs two divisions
// each division runs on the shared radix-2 divider, 32 steps per division
// the output register lets the next item be accepted while a result waits;
//   a held result stalls the sequencer in its final state until taken
// reset: config returns to 192 ppqn, mode off, 64 sixteenths per wrap;
//   last clocked tick clears to zero and no result is pending
module midi_clock_pulse_generator_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic [mcpg_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mcpg_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 item_valid,
	output logic                                 item_stall,
	input  mcpg_pkg::item_t                      item,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output mcpg_pkg::result_t                    result
);

	mcpg_pkg::cfg_t      cfg_q;
	mcpg_pkg::div_req_t  div_req;
	mcpg_pkg::div_rsp_t  div_rsp;

	// config register file, write only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pulses_per_quarter <= mcpg_pkg::PPQN_RESET;
			cfg_q.clock_mode <= mcpg_pkg::MODE_RESET;
			cfg_q.sixteenths_per_wrap <= mcpg_pkg::SPW_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				mcpg_pkg::CFG_PPQN: cfg_q.pulses_per_quarter <= cfg_data;
				mcpg_pkg::CFG_MODE: cfg_q.clock_mode <= cfg_data[mcpg_pkg::MODE_W-1:0];
				mcpg_pkg::CFG_SPW: cfg_q.sixteenths_per_wrap <= cfg_data[mcpg_pkg::SPW_W-1:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	// sequencer with last tick state and output register
	mcpg_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.div_req      (div_req),
		.div_rsp      (div_rsp)
	);

	// shared divider for beat position, alignment and pulse counts
	mcpg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

endmodule
